>>> sv/anbp_pkg.sv
// ----------------------------------------------------------------------------
// anbp_pkg
// Shared types, constants and helpers for the an+b count parser.
// ----------------------------------------------------------------------------
package anbp_pkg;

	// Widths of the fixed fields.
	localparam int CHAR_W   = 8;
	localparam int LIMIT_W  = 20;
	localparam int OUT_W    = 21;
	localparam int STATUS_W = 3;

	// Default magnitude width of the digit accumulator.
	localparam int COUNT_WIDTH_DEF = 20;

	// Reset value of the count limit register.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000000);

	// Queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration port: one register slot per 4 bytes.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_COUNT_LIMIT = 1'b0;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_COUNT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_NUMBER = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVER     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TRAILING = 3'd4;

	// Characters the parser looks for.
	localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
	localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
	localparam logic [CHAR_W-1:0] CH_E     = 8'h65;
	localparam logic [CHAR_W-1:0] CH_V     = 8'h76;
	localparam logic [CHAR_W-1:0] CH_N_LO  = 8'h6E;
	localparam logic [CHAR_W-1:0] CH_N_UP  = 8'h4E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;

	// One classified character as it waits in the queue.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              space;
		logic              digit;
		logic [3:0]        dval;
		logic              letter_n;
		logic              plus;
		logic              minus;
		logic              ident;
	} cls_t;

	// Queue status seen by the front and back ends.
	typedef struct packed {
		logic full;
		logic avail;
	} q_stat_t;

	// Expected letter of the word odd or even at a given position.
	function automatic logic [CHAR_W-1:0] word_letter(input logic even, input logic [2:0] idx);
		logic [CHAR_W-1:0] l;
		l = CH_O;
		unique case ({even, idx})
			4'b0_000: l = CH_O;
			4'b0_001: l = CH_D;
			4'b0_010: l = CH_D;
			4'b1_000: l = CH_E;
			4'b1_001: l = CH_V;
			4'b1_010: l = CH_E;
			4'b1_011: l = CH_N_LO;
			default:  l = CH_O;
		endcase
		return l;
	endfunction

endpackage

>>> sv/anbp_front.sv
// ----------------------------------------------------------------------------
// anbp_front
// Accepts character beats and classifies each one for the parser back end.
// ----------------------------------------------------------------------------
module anbp_front (
	input  logic                            in_valid,
	input  logic [anbp_pkg::CHAR_W-1:0]     character,
	input  logic                            last,
	input  anbp_pkg::q_stat_t               q_stat,
	output logic                            in_stall,
	output logic                            push,
	output anbp_pkg::cls_t                  entry
);
	import anbp_pkg::*;

	logic is_digit;
	logic is_letter;

	// Stall only while the queue has no free slot.
	assign in_stall = q_stat.full;
	assign push     = in_valid & ~q_stat.full;

	// Character classes used by the back end.
	assign is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
	assign is_letter = ((character >= CH_A_LO) && (character <= CH_Z_LO)) ||
		((character >= CH_A_UP) && (character <= CH_Z_UP));

	always_comb begin
		entry.ch       = character;
		entry.last     = last;
		entry.space    = (character == CH_SPACE) || (character == CH_TAB) ||
			(character == CH_LF) || (character == CH_CR);
		entry.digit    = is_digit;
		entry.dval     = character[3:0];
		entry.letter_n = (character == CH_N_LO) || (character == CH_N_UP);
		entry.plus     = (character == CH_PLUS);
		entry.minus    = (character == CH_MINUS);
		entry.ident    = is_letter || is_digit || (character == CH_UNDER) ||
			(character == CH_MINUS);
	end

endmodule

>>> sv/anbp_queue.sv
// ----------------------------------------------------------------------------
// anbp_queue
// Short FIFO of classified characters between the front and back ends.
// ----------------------------------------------------------------------------
module anbp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  anbp_pkg::cls_t     push_data,
	input  logic               pop,
	output anbp_pkg::cls_t     head,
	output anbp_pkg::q_stat_t  q_stat
);
	import anbp_pkg::*;

	cls_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head         = slot_q[rd_ptr_q];
	assign q_stat.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign q_stat.avail = (count_q != '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/anbp_back.sv
// ----------------------------------------------------------------------------
// anbp_back
// Parser FSM, result register: one queued character per cycle unless stalled.
// ----------------------------------------------------------------------------
module anbp_back #(
	parameter int COUNT_WIDTH = anbp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [anbp_pkg::LIMIT_W-1:0]         limit,
	input  anbp_pkg::cls_t                       head,
	input  anbp_pkg::q_stat_t                    q_stat,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [anbp_pkg::OUT_W-1:0]    step,
	output logic signed [anbp_pkg::OUT_W-1:0]    offset,
	output logic [anbp_pkg::STATUS_W-1:0]        status
);
	import anbp_pkg::*;

	// Parser phases.
	localparam logic [2:0] PH_LEAD    = 3'd0;
	localparam logic [2:0] PH_ODD     = 3'd1;
	localparam logic [2:0] PH_EVEN    = 3'd2;
	localparam logic [2:0] PH_NUM     = 3'd3;
	localparam logic [2:0] PH_AFTER_N = 3'd4;
	localparam logic [2:0] PH_OFFSET  = 3'd5;
	localparam logic [2:0] PH_DONE    = 3'd6;
	localparam logic [2:0] PH_ERR     = 3'd7;

	// Offset sign codes.
	localparam logic [1:0] SG_NONE  = 2'd0;
	localparam logic [1:0] SG_PLUS  = 2'd1;
	localparam logic [1:0] SG_MINUS = 2'd2;

	localparam int VW = ((COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W) + 4;
	localparam logic signed [OUT_W-1:0] STEP_WORD = OUT_W'(2);
	localparam logic signed [OUT_W-1:0] STEP_ONE  = OUT_W'(1);

	logic [2:0]               phase_q, n_phase;
	logic [2:0]               prog_q, n_prog;
	logic                     neg_q, n_neg;
	logic [COUNT_WIDTH-1:0]   mag_q, n_mag;
	logic                     seen_q, n_seen;
	logic signed [OUT_W-1:0]  step_q, n_step;
	logic [1:0]               osign_q, n_osign;
	logic [STATUS_W-1:0]      err_q, n_err;

	logic [VW-1:0]            mag_w, acc_v, cap_v, limit_v;
	logic                     over;
	logic signed [OUT_W-1:0]  mag_out;
	logic                     num_c;
	logic                     trail_c;
	logic                     is_even;
	logic [2:0]               wlen;

	logic                     f_ok;
	logic [STATUS_W-1:0]      f_code;
	logic signed [OUT_W-1:0]  f_step;
	logic [COUNT_WIDTH-1:0]   f_mag;
	logic                     f_minus;
	logic [VW-1:0]            f_mag_w;
	logic signed [OUT_W-1:0]  r_step, r_offset;
	logic [STATUS_W-1:0]      r_status;

	logic                     out_free;
	logic                     valid_q;
	logic signed [OUT_W-1:0]  step_r_q, offset_r_q;
	logic [STATUS_W-1:0]      status_r_q;

	// Take a beat unless it would finish into a full result register.
	assign out_free = ~valid_q | ~out_stall;
	assign pop      = q_stat.avail & (~head.last | out_free);

	// Decimal accumulate and compare against the capped limit.
	always_comb begin
		mag_w   = {{(VW-COUNT_WIDTH){1'b0}}, mag_q};
		acc_v   = (mag_w << 3) + (mag_w << 1) + {{(VW-4){1'b0}}, head.dval};
		cap_v   = {{(VW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
		limit_v = {{(VW-LIMIT_W){1'b0}}, limit};
		if (cap_v < limit_v) begin
			limit_v = cap_v;
		end
		over    = acc_v > limit_v;
		mag_out = mag_w[OUT_W-1:0];
	end

	// Next parser state for the character at the head of the queue.
	always_comb begin
		n_phase = phase_q;
		n_prog  = prog_q;
		n_neg   = neg_q;
		n_mag   = mag_q;
		n_seen  = seen_q;
		n_step  = step_q;
		n_osign = osign_q;
		n_err   = err_q;
		num_c   = 1'b0;
		trail_c = 1'b0;
		is_even = (phase_q == PH_EVEN);
		wlen    = is_even ? 3'd4 : 3'd3;

		unique case (phase_q) inside
			PH_LEAD: begin
				if (!head.space) begin
					if (head.ch == CH_O) begin
						n_phase = PH_ODD;
						n_prog  = 3'd1;
					end else if (head.ch == CH_E) begin
						n_phase = PH_EVEN;
						n_prog  = 3'd1;
					end else begin
						n_phase = PH_NUM;
						n_mag   = '0;
						n_seen  = 1'b0;
						if (head.minus) begin
							n_neg = 1'b1;
						end else if (!head.plus) begin
							num_c = 1'b1;
						end
					end
				end
			end
			PH_ODD, PH_EVEN: begin
				if (prog_q < wlen) begin
					if (head.ch == word_letter(is_even, prog_q)) begin
						n_prog = prog_q + 3'd1;
					end else begin
						n_phase = PH_ERR;
						n_err   = ST_NOT_COUNT;
					end
				end else if (head.ident) begin
					n_phase = PH_ERR;
					n_err   = ST_NOT_COUNT;
				end else begin
					n_phase = PH_DONE;
					n_step  = STEP_WORD;
					n_mag   = {{(COUNT_WIDTH-1){1'b0}}, ~is_even};
					n_osign = SG_PLUS;
					trail_c = 1'b1;
				end
			end
			PH_NUM: begin
				num_c = 1'b1;
			end
			PH_AFTER_N: begin
				if (!head.space) begin
					if (head.plus || head.minus) begin
						n_osign = head.minus ? SG_MINUS : SG_PLUS;
						n_phase = PH_OFFSET;
						n_mag   = '0;
						n_seen  = 1'b0;
					end else begin
						n_phase = PH_DONE;
						n_mag   = '0;
						n_osign = SG_NONE;
						trail_c = 1'b1;
					end
				end
			end
			PH_OFFSET: begin
				if (head.digit) begin
					if (over) begin
						n_phase = PH_ERR;
						n_err   = ST_OVER;
					end else begin
						n_mag  = acc_v[COUNT_WIDTH-1:0];
						n_seen = 1'b1;
					end
				end else if (!seen_q) begin
					if (!head.space) begin
						n_phase = PH_ERR;
						n_err   = ST_NO_NUMBER;
					end
				end else begin
					n_phase = PH_DONE;
					trail_c = 1'b1;
				end
			end
			PH_DONE: begin
				trail_c = 1'b1;
			end
			PH_ERR: begin
				n_phase = PH_ERR;
			end
			default: begin
				n_phase = PH_ERR;
			end
		endcase

		// Signed decimal run, step or bare number.
		if (num_c) begin
			if (head.digit) begin
				if (over) begin
					n_phase = PH_ERR;
					n_err   = ST_OVER;
				end else begin
					n_mag  = acc_v[COUNT_WIDTH-1:0];
					n_seen = 1'b1;
				end
			end else if (head.letter_n) begin
				if (seen_q) begin
					n_step = neg_q ? -mag_out : mag_out;
				end else begin
					n_step = neg_q ? -STEP_ONE : STEP_ONE;
				end
				n_phase = PH_AFTER_N;
			end else if (seen_q) begin
				n_phase = PH_DONE;
				n_step  = '0;
				n_osign = neg_q ? SG_MINUS : SG_PLUS;
				trail_c = 1'b1;
			end else begin
				n_phase = PH_ERR;
				n_err   = ST_NOT_COUNT;
			end
		end

		// Only whitespace may follow a complete count.
		if (trail_c && !head.space) begin
			n_phase = PH_ERR;
			n_err   = ST_TRAILING;
		end
	end

	// Close the argument on its last character.
	always_comb begin
		f_ok    = 1'b1;
		f_code  = ST_OK;
		f_step  = n_step;
		f_mag   = n_mag;
		f_minus = (n_osign == SG_MINUS);
		unique case (n_phase)
			PH_LEAD: begin
				f_ok   = 1'b0;
				f_code = ST_NOT_COUNT;
			end
			PH_ODD: begin
				f_step  = STEP_WORD;
				f_mag   = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
				f_minus = 1'b0;
				if (n_prog != 3'd3) begin
					f_ok   = 1'b0;
					f_code = ST_NOT_COUNT;
				end
			end
			PH_EVEN: begin
				f_step  = STEP_WORD;
				f_mag   = '0;
				f_minus = 1'b0;
				if (n_prog != 3'd4) begin
					f_ok   = 1'b0;
					f_code = ST_NOT_COUNT;
				end
			end
			PH_NUM: begin
				f_step  = '0;
				f_minus = n_neg;
				if (!n_seen) begin
					f_ok   = 1'b0;
					f_code = ST_NOT_COUNT;
				end
			end
			PH_AFTER_N: begin
				f_mag   = '0;
				f_minus = 1'b0;
			end
			PH_OFFSET: begin
				if (!n_seen) begin
					f_ok   = 1'b0;
					f_code = ST_NO_NUMBER;
				end
			end
			PH_DONE: begin
				f_ok = 1'b1;
			end
			PH_ERR: begin
				f_ok   = 1'b0;
				f_code = n_err;
			end
			default: begin
				f_ok   = 1'b0;
				f_code = n_err;
			end
		endcase

		f_mag_w = {{(VW-COUNT_WIDTH){1'b0}}, f_mag};
		if (f_ok) begin
			r_status = ST_OK;
			r_step   = f_step;
			r_offset = f_minus ? -f_mag_w[OUT_W-1:0] : f_mag_w[OUT_W-1:0];
		end else begin
			r_status = f_code;
			r_step   = '0;
			r_offset = '0;
		end
	end

	// Parser state registers; cleared after each last character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			prog_q  <= '0;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			seen_q  <= 1'b0;
			step_q  <= '0;
			osign_q <= SG_NONE;
			err_q   <= ST_OK;
		end else if (pop) begin
			if (head.last) begin
				phase_q <= PH_LEAD;
				prog_q  <= '0;
				neg_q   <= 1'b0;
				mag_q   <= '0;
				seen_q  <= 1'b0;
				step_q  <= '0;
				osign_q <= SG_NONE;
				err_q   <= ST_OK;
			end else begin
				phase_q <= n_phase;
				prog_q  <= n_prog;
				neg_q   <= n_neg;
				mag_q   <= n_mag;
				seen_q  <= n_seen;
				step_q  <= n_step;
				osign_q <= n_osign;
				err_q   <= n_err;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && head.last) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			step_r_q   <= r_step;
			offset_r_q <= r_offset;
			status_r_q <= r_status;
		end
	end

	assign out_valid = valid_q;
	assign step      = step_r_q;
	assign offset    = offset_r_q;
	assign status    = status_r_q;

endmodule

>>> sv/an_plus_b_count_parser_top.sv
// A result is registered once its last character beat has been queued and parsed.
// Throughput: one character beat per cycle unless in_stall; the parser back end retires
// one queued character each cycle behind a four-entry queue, unless the result stalls.
// Reset: arst_n clears the parser, queue and result valid flag at once and loads the
// count limit with 1000000; no clearing pass is needed.
// ----------------------------------------------------------------------------
// an_plus_b_count_parser_top
// Parses a CSS an+b count argument character by character into step and offset.
// ----------------------------------------------------------------------------
module an_plus_b_count_parser_top #(
	parameter int COUNT_WIDTH = anbp_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port.
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [anbp_pkg::ADDR_W-1:0]          paddr,
	input  logic [anbp_pkg::DATA_W-1:0]          pwdata,
	output logic [anbp_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready,
	// Character input.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [anbp_pkg::CHAR_W-1:0]          character,
	input  logic                                 last,
	// Result output.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [anbp_pkg::OUT_W-1:0]    step,
	output logic signed [anbp_pkg::OUT_W-1:0]    offset,
	output logic [anbp_pkg::STATUS_W-1:0]        status
);
	import anbp_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               limit_sel;
	logic               push;
	logic               pop;
	cls_t               push_data;
	cls_t               head;
	q_stat_t            q_stat;

	// Register decode and access.
	assign pready    = 1'b1;
	assign limit_sel = (paddr[ADDR_W-1] == REG_COUNT_LIMIT);
	assign prdata    = limit_sel ? {{(DATA_W-LIMIT_W){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && limit_sel) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	anbp_front u_front (
		.in_valid  (in_valid),
		.character (character),
		.last      (last),
		.q_stat    (q_stat),
		.in_stall  (in_stall),
		.push      (push),
		.entry     (push_data)
	);

	anbp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	anbp_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.limit     (limit_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.step      (step),
		.offset    (offset),
		.status    (status)
	);

endmodule

>>> sv/anbp_checker.sv
// ----------------------------------------------------------------------------
// anbp_checker
// Port-level checks on the result channel of the an+b count parser.
// ----------------------------------------------------------------------------
module anbp_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [anbp_pkg::OUT_W-1:0]    step,
	input  logic signed [anbp_pkg::OUT_W-1:0]    offset,
	input  logic [anbp_pkg::STATUS_W-1:0]        status
);
	import anbp_pkg::*;

	localparam logic [OUT_W-1:0] MOST_NEG = {1'b1, {(OUT_W-1){1'b0}}};

	// A stalled result beat holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(step) && $stable(offset) &&
			$stable(status))
		else $error("result beat changed while stalled");

	// Error results carry zero step and offset.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (step == '0) && (offset == '0))
		else $error("error result with nonzero fields");

	// Only defined status codes appear.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_NOT_COUNT) ||
			(status == ST_NO_NUMBER) || (status == ST_OVER) || (status == ST_TRAILING))
		else $error("undefined status code");

	// Good results stay within the signed magnitude range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_OK) |-> (step != MOST_NEG) && (offset != MOST_NEG))
		else $error("result magnitude out of range");

endmodule

bind an_plus_b_count_parser_top anbp_checker u_anbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.step      (step),
	.offset    (offset),
	.status    (status)
);

>>> tb/tb_an_plus_b_count_parser_top.sv
// ----------------------------------------------------------------------------
// tb_an_plus_b_count_parser_top
// Self-checking bench for the an+b count parser. Argument texts are sent one
// character beat at a time and every result beat is compared with a count
// from the table or from a behavioral parser in the bench. Directed texts
// come first; randomly built texts follow under several count limit settings,
// with random idle cycles on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_an_plus_b_count_parser_top;
	timeunit 1ns;
	timeprecision 1ps;

	import anbp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int PHASE_CHARS    = 265;
	localparam string JUMBLE      = "0123456789+-nNoddeven \t_x";

	// Parser phases of the behavioral copy.
	typedef enum logic [3:0] {
		PS_LEAD, PS_ODD, PS_EVEN, PS_NUM, PS_AFTER_N, PS_OFFSET, PS_DONE, PS_ERR
	} parse_phase_e;

	// Sign held for the offset.
	typedef enum logic [1:0] {SG_NONE, SG_PLUS, SG_MINUS} sign_e;

	// One parsed count as it leaves the block.
	typedef struct {
		logic signed [OUT_W-1:0] step;
		logic signed [OUT_W-1:0] offset;
		logic [STATUS_W-1:0]     status;
	} count_t;

	// One directed text, optionally preceded by a new count limit.
	typedef struct {
		bit          reconfig;
		logic [31:0] limit;
		string       text;
		bit          known;
		int          a;
		int          b;
		logic [2:0]  st;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CHAR_W-1:0] character = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OUT_W-1:0] step;
	logic signed [OUT_W-1:0] offset;
	logic [STATUS_W-1:0] status;

	an_plus_b_count_parser_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .character(character), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.step(step), .offset(offset), .status(status)
	);

	always #2 clk = ~clk;

	// Bench state.
	count_t counts_due[$];
	logic [7:0] arg_bytes[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	logic calm = 1'b0;

	// Behavioral parser state.
	logic [LIMIT_W-1:0] limit_shadow = LIMIT_RESET;
	parse_phase_e ps_phase;
	int ps_word;
	bit ps_neg;
	int unsigned ps_mag;
	bit ps_digits;
	int ps_step;
	sign_e ps_sign;
	logic [2:0] ps_err;

	// ------------------------------------------------------------------------
	// Behavioral parser.
	// ------------------------------------------------------------------------
	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_name_char(logic [7:0] c);
		return (c >= CH_A_LO && c <= CH_Z_LO) || (c >= CH_A_UP && c <= CH_Z_UP) ||
			c == CH_UNDER || is_num(c) || c == CH_MINUS;
	endfunction

	function automatic void clear_parse();
		ps_phase = PS_LEAD;
		ps_word = 0;
		ps_neg = 1'b0;
		ps_mag = 0;
		ps_digits = 1'b0;
		ps_step = 0;
		ps_sign = SG_NONE;
		ps_err = ST_OK;
	endfunction

	function automatic void reject(logic [2:0] code);
		ps_phase = PS_ERR;
		ps_err = code;
	endfunction

	function automatic void settle(int a, int unsigned m, sign_e s);
		ps_phase = PS_DONE;
		ps_step = a;
		ps_mag = m;
		ps_sign = s;
	endfunction

	// Only whitespace may follow a complete count.
	function automatic void after_count(logic [7:0] c);
		if (!is_blank(c)) begin
			reject(ST_TRAILING);
		end
	endfunction

	// A digit run is refused as soon as it passes the limit.
	function automatic void add_digit(logic [7:0] c);
		int unsigned v;
		v = ps_mag * 10 + 32'(c - CH_ZERO);
		if (v > limit_shadow) begin
			reject(ST_OVER);
		end else begin
			ps_mag = v;
			ps_digits = 1'b1;
		end
	endfunction

	function automatic void number_char(logic [7:0] c);
		int m;
		if (is_num(c)) begin
			add_digit(c);
		end else if (c == CH_N_LO || c == CH_N_UP) begin
			m = ps_digits ? int'(ps_mag) : 1;
			ps_step = ps_neg ? -m : m;
			ps_phase = PS_AFTER_N;
		end else if (ps_digits) begin
			settle(0, ps_mag, ps_neg ? SG_MINUS : SG_PLUS);
			after_count(c);
		end else begin
			reject(ST_NOT_COUNT);
		end
	endfunction

	// The words must match exactly and may not run on into a longer name.
	function automatic void word_char(logic [7:0] c, bit even);
		string w;
		w = even ? "even" : "odd";
		if (ps_word < w.len()) begin
			if (c == w[ps_word]) begin
				ps_word++;
			end else begin
				reject(ST_NOT_COUNT);
			end
		end else if (is_name_char(c)) begin
			reject(ST_NOT_COUNT);
		end else begin
			settle(2, even ? 0 : 1, SG_PLUS);
			after_count(c);
		end
	endfunction

	function automatic void take(logic [7:0] c);
		case (ps_phase)
			PS_LEAD: begin
				if (c == CH_O) begin
					ps_phase = PS_ODD;
					ps_word = 1;
				end else if (c == CH_E) begin
					ps_phase = PS_EVEN;
					ps_word = 1;
				end else if (!is_blank(c)) begin
					ps_phase = PS_NUM;
					ps_mag = 0;
					ps_digits = 1'b0;
					if (c == CH_MINUS) begin
						ps_neg = 1'b1;
					end else if (c != CH_PLUS) begin
						number_char(c);
					end
				end
			end
			PS_ODD: word_char(c, 1'b0);
			PS_EVEN: word_char(c, 1'b1);
			PS_NUM: number_char(c);
			PS_AFTER_N: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					ps_sign = (c == CH_MINUS) ? SG_MINUS : SG_PLUS;
					ps_phase = PS_OFFSET;
					ps_mag = 0;
					ps_digits = 1'b0;
				end else if (!is_blank(c)) begin
					settle(ps_step, 0, SG_NONE);
					after_count(c);
				end
			end
			PS_OFFSET: begin
				// Spaces may sit between the offset sign and its digits.
				if (is_num(c)) begin
					add_digit(c);
				end else if (!ps_digits) begin
					if (!is_blank(c)) begin
						reject(ST_NO_NUMBER);
					end
				end else begin
					settle(ps_step, ps_mag, ps_sign);
					after_count(c);
				end
			end
			PS_DONE: after_count(c);
			default: ;
		endcase
	endfunction

	// End of text: decide whether what was read forms a whole count.
	function automatic void close_out();
		case (ps_phase)
			PS_LEAD: reject(ST_NOT_COUNT);
			PS_ODD: begin
				if (ps_word == 3) settle(2, 1, SG_PLUS);
				else reject(ST_NOT_COUNT);
			end
			PS_EVEN: begin
				if (ps_word == 4) settle(2, 0, SG_PLUS);
				else reject(ST_NOT_COUNT);
			end
			PS_NUM: begin
				if (ps_digits) settle(0, ps_mag, ps_neg ? SG_MINUS : SG_PLUS);
				else reject(ST_NOT_COUNT);
			end
			PS_AFTER_N: settle(ps_step, 0, SG_NONE);
			PS_OFFSET: begin
				if (ps_digits) settle(ps_step, ps_mag, ps_sign);
				else reject(ST_NO_NUMBER);
			end
			default: ;
		endcase
	endfunction

	// Feeds one character beat; returns 1 with the count when it is the last one.
	function automatic bit predict_count(logic [7:0] c, logic l, output count_t r);
		take(c);
		r.step = '0;
		r.offset = '0;
		r.status = ST_OK;
		if (!l) begin
			return 1'b0;
		end
		close_out();
		if (ps_phase == PS_DONE) begin
			r.step = OUT_W'(ps_step);
			r.offset = OUT_W'((ps_sign == SG_MINUS) ? -int'(ps_mag) : int'(ps_mag));
		end else begin
			r.status = ps_err;
		end
		clear_parse();
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	// Appends one character to the text being built.
	function automatic void add_char(logic [7:0] c);
		arg_bytes.insert(arg_bytes.size(), c);
	endfunction

	function automatic void put_blanks(int most);
		repeat ($urandom_range(0, most)) begin
			case ($urandom_range(0, 3))
				0: add_char(CH_SPACE);
				1: add_char(CH_TAB);
				2: add_char(CH_LF);
				default: add_char(CH_CR);
			endcase
		end
	endfunction

	function automatic void put_sign();
		case ($urandom_range(0, 2))
			1: add_char(CH_PLUS);
			2: add_char(CH_MINUS);
			default: ;
		endcase
	endfunction

	// Mostly short runs; the longer ones reach past most limits.
	function automatic void put_digits();
		int n;
		n = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 3) : $urandom_range(4, 7);
		repeat (n) add_char(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	// Builds one random argument text, mostly well formed.
	function automatic void compose_argument();
		int kind;
		string w;
		arg_bytes.delete();
		if ($urandom_range(0, 2) == 0) put_blanks(3);
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			w = $urandom_range(0, 1) ? "odd" : "even";
			for (int k = 0; k < w.len(); k++) add_char(w[k]);
		end else if (kind < 50) begin
			put_sign();
			if ($urandom_range(0, 3) != 0) put_digits();
			add_char($urandom_range(0, 3) == 0 ? CH_N_UP : CH_N_LO);
			if ($urandom_range(0, 3) != 0) begin
				put_blanks(2);
				add_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				put_blanks(2);
				put_digits();
			end
		end else if (kind < 75) begin
			put_sign();
			put_digits();
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 5)) add_char(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 8))
				add_char(JUMBLE[$urandom_range(0, JUMBLE.len() - 1)]);
		end
		if ($urandom_range(0, 3) == 0) put_blanks(2);
		if ($urandom_range(0, 11) == 0) add_char(8'($urandom_range(0, 255)));
		// Break a share of the texts by cutting or corrupting one character.
		if (arg_bytes.size() > 1 && $urandom_range(0, 9) == 0) void'(arg_bytes.pop_back());
		if (arg_bytes.size() > 0 && $urandom_range(0, 9) == 0)
			arg_bytes[$urandom_range(0, arg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		if (arg_bytes.size() == 0) add_char(CH_SPACE);
	endfunction

	// Sends the text in arg_bytes and queues the count it should produce.
	task automatic send_argument(bit known, count_t typed);
		int gap;
		count_t got;
		for (int k = 0; k < arg_bytes.size(); k++) begin
			gap = draw_wait();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			character <= arg_bytes[k];
			last <= (k == arg_bytes.size() - 1);
			do @(posedge clk); while (in_stall);
			if (predict_count(arg_bytes[k], k == arg_bytes.size() - 1, got))
				counts_due.insert(counts_due.size(), known ? typed : got);
		end
	endtask

	// Waits until every queued count has come back and the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (counts_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the count limit, then reads it back.
	task automatic set_count_limit(logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * REG_COUNT_LIMIT);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		limit_shadow = value[LIMIT_W-1:0];
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[LIMIT_W-1:0] !== limit_shadow) begin
			mismatches++;
			$display("%0t: count limit expected %0d, actual %0d", $time, limit_shadow,
				prdata[LIMIT_W-1:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// ------------------------------------------------------------------------
	// Directed texts. Rows with known set carry a count read straight off the
	// rules; the rest are checked against the behavioral parser.
	// ------------------------------------------------------------------------
	probe_t probes[] = '{
		'{0, 0, "odd", 1, 2, 1, ST_OK},
		'{0, 0, "even", 1, 2, 0, ST_OK},
		'{0, 0, " \t\n\015odd", 1, 2, 1, ST_OK},
		'{0, 0, "even \t", 1, 2, 0, ST_OK},
		'{0, 0, "odd x", 1, 0, 0, ST_TRAILING},
		'{0, 0, "oddx", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, "od", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, "odd-", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, "evex", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, " ", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, "+", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, "- ", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, "?7n", 1, 0, 0, ST_NOT_COUNT},
		'{0, 0, "1000000", 1, 0, 1000000, ST_OK},
		'{0, 0, "-1000000", 1, 0, -1000000, ST_OK},
		'{0, 0, "1000001", 1, 0, 0, ST_OVER},
		'{0, 0, "n", 1, 1, 0, ST_OK},
		'{0, 0, "-N", 1, -1, 0, ST_OK},
		'{0, 0, "3n+", 1, 0, 0, ST_NO_NUMBER},
		'{0, 0, "3n + x", 1, 0, 0, ST_NO_NUMBER},
		'{0, 0, "5n 3", 1, 0, 0, ST_TRAILING},
		'{0, 0, "4x", 1, 0, 0, ST_TRAILING},
		'{0, 0, "+n-0", 0, 0, 0, ST_OK},
		'{0, 0, " -7n - 12 ", 0, 0, 0, ST_OK},
		'{0, 0, "0n+0", 0, 0, 0, ST_OK},
		'{0, 0, "12 ", 0, 0, 0, ST_OK},
		'{1, 32'h000F_FFFF, "-1048575n+1048575", 1, -1048575, 1048575, ST_OK},
		'{0, 0, "1048576", 1, 0, 0, ST_OVER},
		'{1, 32'h0, "n-0", 1, 1, 0, ST_OK},
		'{0, 0, "0", 1, 0, 0, ST_OK},
		'{0, 0, "1", 1, 0, 0, ST_OVER},
		'{0, 0, "-n+01", 1, 0, 0, ST_OVER}
	};

	// Count limits of the random phases: all ones, zero, small, mid, random, reset value.
	logic [31:0] phase_limits [6];

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		count_t typed;
		count_t none;
		int sent;
		none = '{default: '0};
		clear_parse();
		phase_limits = '{32'hFFFF_FFFF, 32'h0, 32'd7, 32'd99999,
			32'($urandom_range(0, 1048575)), 32'd1000000};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			if (probes[i].reconfig) begin
				drain();
				set_count_limit(probes[i].limit);
			end
			arg_bytes.delete();
			for (int k = 0; k < probes[i].text.len(); k++)
				add_char(probes[i].text[k]);
			typed.step = OUT_W'(probes[i].a);
			typed.offset = OUT_W'(probes[i].b);
			typed.status = probes[i].st;
			send_argument(probes[i].known, typed);
		end

		foreach (phase_limits[p]) begin
			drain();
			set_count_limit(phase_limits[p]);
			sent = 0;
			while (sent < PHASE_CHARS) begin
				compose_argument();
				send_argument(1'b0, none);
				sent += arg_bytes.size();
			end
		end
		drain();

		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Alternates stretches with random idling and stretches with none.
	initial begin
		forever begin
			calm <= 1'b0;
			repeat ($urandom_range(200, 800)) @(posedge clk);
			calm <= 1'b1;
			repeat ($urandom_range(50, 200)) @(posedge clk);
		end
	end

	// Result side: random stall, then take one beat and compare it.
	initial begin
		int hold;
		count_t want;
		forever begin
			hold = draw_wait();
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (counts_due.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with none expected: step %0d offset %0d status %0d",
					$time, step, offset, status);
			end else begin
				want = counts_due.pop_front();
				check_field("step", want.step, step);
				check_field("offset", want.offset, offset);
				check_field("status", want.status, status);
			end
		end
	end

	// Watchdog on cycles in which no beat and no register access moves.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

>>> sim.f
sv/anbp_pkg.sv
sv/anbp_front.sv
sv/anbp_queue.sv
sv/anbp_back.sv
sv/an_plus_b_count_parser_top.sv
sv/anbp_checker.sv
tb/tb_an_plus_b_count_parser_top.sv
